>>> sv/iul_pkg.sv
// Package for interval_union_length: shared widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package iul_pkg;
  localparam int unsigned TimeW = 34;
  localparam int unsigned TotW  = 31;
  localparam logic [TotW-1:0] SatLimit = {TotW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SWEEP_RD,
    ST_SWEEP,
    ST_DONE,
    ST_OUT
  } state_e;
endpackage

>>> sv/iul_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iul_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/interval_union_length.sv
// interval_union_length: length of the union of a set of intervals.
// Depends on iul_pkg and iul_ram.
//
//  channel | signals                                       | dir
//  in      | in_valid_i/in_ready_o, interval_*_i, last_item_i | in
//  out     | out_valid_o/out_ready_i, total_seconds_o, saturated_o, overflow_o | out
//
// Insertion: each stored entry that sorts after the new one is shifted up, then it is written.
// Closing sweep: reads the stored entries in order, merges overlaps, then the result register.
// A pending result stalls the block until taken. Reset clears state, count and overflow flag only.
`timescale 1ns / 1ps
module interval_union_length
  import iul_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TimeW-1:0] interval_start_i,
  input  logic [TimeW-1:0] interval_end_i,
  input  logic             last_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TotW-1:0]  total_seconds_o,
  output logic             saturated_o,
  output logic             overflow_o
);
  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] Cap = CW'(MAX_INTERVALS);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic ovf_q, ovf_d, last_q, last_d;
  logic [TimeW-1:0] s_q, s_d, e_q, e_d, cs_q, cs_d, ce_q, ce_d;
  logic [TimeW+AW:0] acc_q, acc_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic sat_q, sat_d, ovo_q, ovo_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [TimeW-1:0] wds, wde, rds, rde;
  logic after;

  iul_ram #(.Width(TimeW), .Depth(MAX_INTERVALS)) u_start (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wds), .raddr_i(raddr), .rdata_o(rds)
  );
  iul_ram #(.Width(TimeW), .Depth(MAX_INTERVALS)) u_end (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wde), .raddr_i(raddr), .rdata_o(rde)
  );

  assign after = (rds != s_q) ? (rds > s_q) : (rde > e_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign total_seconds_o = tot_q;
  assign saturated_o = sat_q;
  assign overflow_o = ovo_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pos_d = pos_q; ovf_d = ovf_q; last_d = last_q;
    s_d = s_q; e_d = e_q; cs_d = cs_q; ce_d = ce_q; acc_d = acc_q;
    tot_d = tot_q; sat_d = sat_q; ovo_d = ovo_q;
    we = 1'b0; waddr = pos_q[AW-1:0]; wds = s_q; wde = e_q;
    raddr = AW'(pos_q - CW'(1));
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          s_d = interval_start_i; e_d = interval_end_i; last_d = last_item_i;
          pos_d = cnt_q; raddr = AW'(cnt_q - CW'(1));
          if (interval_end_i > interval_start_i) begin
            if (cnt_q == Cap) begin
              ovf_d = 1'b1;
              state_d = last_item_i ? ST_SWEEP_RD : ST_IDLE;
            end else if (cnt_q == '0) begin
              state_d = ST_SHIFT_WR;
            end else begin
              state_d = ST_SHIFT_RD;
            end
          end else begin
            state_d = last_item_i ? ST_SWEEP_RD : ST_IDLE;
          end
          if (state_d == ST_SWEEP_RD) pos_d = '0;
        end
      end
      ST_SHIFT_RD: begin
        // rds/rde hold entry pos-1
        if (after) begin
          we = 1'b1; wds = rds; wde = rde;
          pos_d = pos_q - CW'(1);
          raddr = AW'(pos_q - CW'(2));
          state_d = (pos_q == CW'(1)) ? ST_SHIFT_WR : ST_SHIFT_RD;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        we = 1'b1;
        cnt_d = cnt_q + CW'(1);
        state_d = last_q ? ST_SWEEP_RD : ST_IDLE;
        pos_d = '0;
      end
      ST_SWEEP_RD: begin
        raddr = '0;
        acc_d = '0;
        pos_d = CW'(1);
        state_d = (cnt_q == '0) ? ST_DONE : ST_SWEEP;
        cs_d = '0; ce_d = '0;
      end
      ST_SWEEP: begin
        raddr = pos_q[AW-1:0];
        if (pos_q == CW'(1)) begin
          cs_d = rds; ce_d = rde;
        end else if (rds <= ce_q) begin
          if (rde > ce_q) ce_d = rde;
        end else begin
          acc_d = acc_q + (TimeW+AW+1)'(ce_q - cs_q);
          cs_d = rds; ce_d = rde;
        end
        pos_d = pos_q + CW'(1);
        if (pos_q == cnt_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        acc_d = acc_q + (TimeW+AW+1)'(ce_q - cs_q);
        state_d = ST_OUT;
        if (acc_d > (TimeW+AW+1)'(SatLimit)) begin
          tot_d = SatLimit; sat_d = 1'b1;
        end else begin
          tot_d = acc_d[TotW-1:0]; sat_d = 1'b0;
        end
        ovo_d = ovf_q;
        cnt_d = '0; ovf_d = 1'b0;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; ovf_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; last_q <= last_d; s_q <= s_d; e_q <= e_d;
    cs_q <= cs_d; ce_q <= ce_d; acc_q <= acc_d;
    tot_q <= tot_d; sat_q <= sat_d; ovo_q <= ovo_d;
  end
endmodule

>>> bench/iul_checker.sv
// Checker for interval_union_length: watches both channels, predicts the union length.
// Depends on iul_pkg.
`timescale 1ns / 1ps
module iul_checker
  import iul_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [TimeW-1:0] interval_start_i,
  input  logic [TimeW-1:0] interval_end_i,
  input  logic             last_item_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [TotW-1:0]  total_seconds_i,
  input  logic             saturated_i,
  input  logic             overflow_i,
  output int               errors_o,
  output int               pending_o
);
  typedef struct packed {
    logic [TotW-1:0] total;
    logic            sat;
    logic            ovf;
  } union_res_t;

  // kept in order by start, then by end
  logic [TimeW-1:0] starts[$];
  logic [TimeW-1:0] ends[$];
  logic             ovf_seen;
  union_res_t       expected_q[$];

  function automatic bit goes_after(input logic [TimeW-1:0] s1, input logic [TimeW-1:0] e1,
                                    input logic [TimeW-1:0] s2, input logic [TimeW-1:0] e2);
    if (s1 != s2) return s1 > s2;
    return e1 > e2;
  endfunction

  function automatic union_res_t sweep_union();
    union_res_t       r;
    logic [TimeW-1:0] cs, ce;
    logic [63:0]      sum;
    sum = 0;
    if (starts.size() > 0) begin
      cs = starts[0];
      ce = ends[0];
      for (int i = 1; i < starts.size(); i++) begin
        if (starts[i] <= ce) begin
          if (ends[i] > ce) ce = ends[i];
        end else begin
          sum += 64'(ce - cs);
          cs = starts[i];
          ce = ends[i];
        end
      end
      sum += 64'(ce - cs);
    end
    r.sat = sum > 64'(SatLimit);
    r.total = r.sat ? SatLimit : sum[TotW-1:0];
    r.ovf = ovf_seen;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    union_res_t exp_r;
    int         pos;
    int         errs;
    if (!rst_ni) begin
      starts.delete();
      ends.delete();
      ovf_seen = 1'b0;
      errors_o <= 0;
    end else begin
      errs = errors_o;
      if (in_valid_i && in_ready_i) begin
        if (interval_end_i > interval_start_i) begin
          if (starts.size() < MAX_INTERVALS) begin
            pos = starts.size();
            while (pos > 0 && goes_after(starts[pos-1], ends[pos-1],
                                         interval_start_i, interval_end_i)) pos--;
            starts.insert(pos, interval_start_i);
            ends.insert(pos, interval_end_i);
          end else begin
            ovf_seen = 1'b1;
          end
        end
        if (last_item_i) begin
          expected_q.push_back(sweep_union());
          starts.delete();
          ends.delete();
          ovf_seen = 1'b0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: total_seconds %0d", total_seconds_i);
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.total !== total_seconds_i) begin
            $error("total_seconds expected %0d actual %0d", exp_r.total, total_seconds_i);
            errs++;
          end
          if (exp_r.sat !== saturated_i) begin
            $error("saturated expected %0d actual %0d", exp_r.sat, saturated_i);
            errs++;
          end
          if (exp_r.ovf !== overflow_i) begin
            $error("overflow expected %0d actual %0d", exp_r.ovf, overflow_i);
            errs++;
          end
        end
      end
      errors_o <= errs;
    end
  end
endmodule

>>> bench/tb_top.sv
// Top of the interval_union_length bench: clock, reset, interval stimulus and verdict.
// Depends on iul_pkg, iul_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import iul_pkg::*;

  localparam int unsigned MaxIv = 256;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [TimeW-1:0] iv_start = '0;
  logic [TimeW-1:0] iv_end = '0;
  logic             last_item = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [TotW-1:0]  total_seconds;
  logic             saturated;
  logic             overflow;
  int               errors;
  int               pending;

  always #10 clk = ~clk;

  interval_union_length #(.MAX_INTERVALS(MaxIv)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .interval_start_i(iv_start), .interval_end_i(iv_end), .last_item_i(last_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .total_seconds_o(total_seconds), .saturated_o(saturated), .overflow_o(overflow)
  );

  iul_checker #(.MAX_INTERVALS(MaxIv)) checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .interval_start_i(iv_start), .interval_end_i(iv_end), .last_item_i(last_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .total_seconds_i(total_seconds), .saturated_i(saturated), .overflow_i(overflow),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  // with valid still high, so the caller drives the next item or drops valid
  task automatic send_interval(input logic [TimeW-1:0] s, input logic [TimeW-1:0] e,
                               input logic lst, input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    iv_start <= s;
    iv_end <= e;
    last_item <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input int span_kind, input bit no_gap);
    logic [TimeW-1:0] s, e;
    for (int i = 0; i < n; i++) begin
      case (span_kind)
        0: begin
          s = TimeW'($urandom_range(0, 2000));
          e = s + TimeW'($urandom_range(0, 300));
        end
        1: begin
          s = TimeW'({$urandom, $urandom});
          e = TimeW'({$urandom, $urandom});
        end
        default: begin
          s = TimeW'($urandom_range(0, 60));
          e = TimeW'($urandom_range(0, 60));
        end
      endcase
      send_interval(s, e, i == n - 1, no_gap);
    end
  endtask

  always begin
    @(negedge clk);
    if (gap_len() > 5) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(5, 40)) @(negedge clk);
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int sent;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: extremes, empty, reversed, touching, saturation
    send_interval('0, '0, 1'b1, 0);
    send_interval(TimeMax, '0, 1'b1, 0);
    send_interval('0, TimeMax, 1'b1, 0);
    send_interval(34'd10, 34'd20, 1'b0, 0);
    send_interval(34'd20, 34'd30, 1'b0, 0);
    send_interval(34'd5, 34'd12, 1'b0, 0);
    send_interval(34'd40, 34'd40, 1'b1, 0);
    send_interval(34'd100, 34'd200, 1'b0, 0);
    send_interval(34'd100, 34'd150, 1'b0, 0);
    send_interval(34'd300, 34'd250, 1'b1, 0);
    send_interval(34'd0, 34'h07FFFFFFF, 1'b0, 0);
    send_interval(34'h080000000, 34'h080000001, 1'b1, 0);
    send_interval(34'd0, 34'h07FFFFFFF, 1'b1, 0);
    send_interval(34'h155555555, 34'h2AAAAAAAA, 1'b1, 0);
    // store full: overflow, then a clean set after it
    send_set(MaxIv + 4, 0, 1);
    send_interval(34'd1, 34'd2, 1'b1, 0);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (MaxIv * 3 + 20) @(negedge clk);
    sent = 0;
    while (sent < 620) begin
      int n, kind;
      n = $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      kind = (kind < 6) ? 0 : (kind < 8) ? 1 : 2;
      send_set(n, kind, $urandom_range(0, 4) == 0);
      sent += n;
      if ($urandom_range(0, 40) == 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (MaxIv * 3 + 20) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
